// ===== hw/rtl/xpfec_pkg.sv =====
// Shared types and constants of the XOR parity packet FEC encoder.
package xpfec_pkg;

    // input beat kinds (tuser)
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam int          LEN_OUT_W          = 11;
    localparam int          POS_W              = 12;
    localparam logic [11:0] POS_MAX            = 12'hFFF;
    localparam logic [4:0]  GRP_PKTS_DEFAULT   = 5'd4;
    localparam logic [4:0]  GRP_PKTS_MIN       = 5'd2;
    localparam int          PARITY_HDR_BYTES   = 4;
    localparam int          CMD_FIFO_DEPTH     = 4;

    // result beat kinds (tuser)
    typedef enum logic [1:0] {
        RK_NOTICE = 2'd0,
        RK_BYTE   = 2'd1,
        RK_IDLE   = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_WRITE = 2'd1,
        MEM_XOR   = 2'd2,
        MEM_READ  = 2'd3
    } t_mem_op;

    // one command from front to back (store address travels beside it)
    typedef struct packed {
        t_mem_op                mem_op;
        logic [7:0]             data;
        logic                   emit;
        t_rkind                 rkind;
        logic                   last;
        logic [LEN_OUT_W-1:0]   len;
        logic [15:0]            seq;
        logic                   ovr;
    } t_cmd;

endpackage

// ===== hw/rtl/xpfec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xpfec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/xpfec_cmd_fifo.sv =====
// Short command queue between the front and back parts.
module xpfec_cmd_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

// ===== hw/rtl/xpfec_front.sv =====
// Front part: accepts beats, tracks packet/group state, issues store commands.
module xpfec_front #(
    parameter int MAX_GROUP        = 16,
    parameter int HEADER_BYTES     = 8,
    parameter int MAX_PARITY_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [4:0]                          i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_kind,
    input  logic [7:0]                          i_data,
    input  logic                                i_last,
    input  logic [15:0]                         i_pseq,
    input  logic [15:0]                         i_nseq,
    output xpfec_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_PARITY_BYTES)-1:0] o_addr
);
    import xpfec_pkg::*;

    localparam int AW  = $clog2(MAX_PARITY_BYTES);
    localparam int LW  = $clog2(MAX_PARITY_BYTES + 1);
    localparam int PLW = $clog2(MAX_PARITY_BYTES + PARITY_HDR_BYTES + 1);

    logic [4:0]       r_grp_pkts;
    logic [LW-1:0]    r_longest, n_longest;
    logic [4:0]       r_pkts, n_pkts;
    logic [15:0]      r_start_seq, n_start_seq;
    logic [7:0]       r_flags_par, n_flags_par;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_cur_flags, n_cur_flags;
    logic             r_pend_valid, n_pend_valid;
    logic [31:0]      r_pend_hdr, n_pend_hdr;
    logic [PLW-1:0]   r_pend_len, n_pend_len;
    logic [10:0]      r_rd_ptr, n_rd_ptr;

    logic             is_hdr, ovr, rd_last;
    logic [12:0]      idx, idx_p1, rp, ri;
    logic [4:0]       pk;

    always_comb begin
        n_longest    = r_longest;
        n_pkts       = r_pkts;
        n_start_seq  = r_start_seq;
        n_flags_par  = r_flags_par;
        n_pos        = r_pos;
        n_cur_flags  = r_cur_flags;
        n_pend_valid = r_pend_valid;
        n_pend_hdr   = r_pend_hdr;
        n_pend_len   = r_pend_len;
        n_rd_ptr     = r_rd_ptr;

        is_hdr  = (r_pos < POS_W'(HEADER_BYTES));
        idx     = {1'b0, r_pos} - 13'(HEADER_BYTES);
        idx_p1  = idx + 13'd1;
        rp      = {2'b00, r_rd_ptr};
        ri      = rp - 13'(PARITY_HDR_BYTES);
        rd_last = ((rp + 13'd1) >= 13'(r_pend_len));
        pk      = r_pkts + 5'd1;
        ovr     = 1'b0;

        o_cmd.mem_op = MEM_NONE;
        o_cmd.data   = 8'd0;
        o_cmd.emit   = 1'b0;
        o_cmd.rkind  = RK_IDLE;
        o_cmd.last   = 1'b0;
        o_cmd.len    = '0;
        o_cmd.seq    = 16'd0;
        o_cmd.ovr    = 1'b0;
        o_addr       = '0;

        if (i_accept) begin
            if (i_kind == KIND_READ) begin
                o_cmd.emit = 1'b1;
                if (r_pend_valid) begin
                    o_cmd.rkind = RK_BYTE;
                    o_cmd.last  = rd_last;
                    o_cmd.len   = LEN_OUT_W'(r_pend_len);
                    if (rp < 13'(PARITY_HDR_BYTES)) begin
                        unique case (r_rd_ptr[1:0])
                            2'd0:    o_cmd.data = r_pend_hdr[31:24];
                            2'd1:    o_cmd.data = r_pend_hdr[23:16];
                            2'd2:    o_cmd.data = r_pend_hdr[15:8];
                            default: o_cmd.data = r_pend_hdr[7:0];
                        endcase
                    end else if (ri < 13'(MAX_PARITY_BYTES)) begin
                        o_cmd.mem_op = MEM_READ;
                        o_addr       = AW'(ri);
                    end
                    if (rd_last) begin
                        n_pend_valid = 1'b0;
                        n_rd_ptr     = 11'd0;
                    end else begin
                        n_rd_ptr = r_rd_ptr + 11'd1;
                    end
                end
            end else begin
                // a packet beat while parity is pending drops it
                if (r_pend_valid) begin
                    n_pend_valid = 1'b0;
                    n_rd_ptr     = 11'd0;
                    ovr          = 1'b1;
                end
                if (is_hdr) begin
                    if (r_pos == POS_W'(3)) begin
                        n_cur_flags = i_data;
                    end
                end else if (idx < 13'(MAX_PARITY_BYTES)) begin
                    // past the longest payload the store is written plainly
                    o_cmd.mem_op = (idx < 13'(r_longest)) ? MEM_XOR : MEM_WRITE;
                    o_cmd.data   = i_data;
                    o_addr       = AW'(idx);
                    if (idx_p1 > 13'(r_longest)) begin
                        n_longest = LW'(idx_p1);
                    end
                end
                n_pos = (r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos;

                if (i_last) begin
                    n_pos       = '0;
                    n_cur_flags = 8'd0;
                    if (!is_hdr) begin
                        if (r_pkts == 5'd0) begin
                            n_start_seq = i_pseq;
                        end
                        n_flags_par = r_flags_par ^ r_cur_flags;
                        n_pkts      = pk;
                        if (pk >= r_grp_pkts) begin
                            n_pend_hdr   = {n_start_seq, 3'b000, pk, n_flags_par};
                            n_pend_len   = PLW'(PARITY_HDR_BYTES) + PLW'(n_longest);
                            n_pend_valid = 1'b1;
                            n_rd_ptr     = 11'd0;
                            n_pkts       = 5'd0;
                            n_flags_par  = 8'd0;
                            n_longest    = '0;
                            o_cmd.emit   = 1'b1;
                            o_cmd.rkind  = RK_NOTICE;
                            o_cmd.len    = LEN_OUT_W'(n_pend_len);
                            o_cmd.seq    = i_nseq;
                            o_cmd.ovr    = ovr;
                        end
                    end
                end
                if (ovr && !o_cmd.emit) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.rkind = RK_IDLE;
                    o_cmd.ovr   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_pkts   <= GRP_PKTS_DEFAULT;
            r_longest    <= '0;
            r_pkts       <= '0;
            r_start_seq  <= '0;
            r_flags_par  <= '0;
            r_pos        <= '0;
            r_cur_flags  <= '0;
            r_pend_valid <= 1'b0;
            r_pend_hdr   <= '0;
            r_pend_len   <= '0;
            r_rd_ptr     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_grp_pkts <= (i_cfg_wdata >= GRP_PKTS_MIN &&
                               32'(i_cfg_wdata) <= MAX_GROUP) ?
                              i_cfg_wdata : GRP_PKTS_DEFAULT;
            end
            r_longest    <= n_longest;
            r_pkts       <= n_pkts;
            r_start_seq  <= n_start_seq;
            r_flags_par  <= n_flags_par;
            r_pos        <= n_pos;
            r_cur_flags  <= n_cur_flags;
            r_pend_valid <= n_pend_valid;
            r_pend_hdr   <= n_pend_hdr;
            r_pend_len   <= n_pend_len;
            r_rd_ptr     <= n_rd_ptr;
        end
    end
endmodule

// ===== hw/rtl/xpfec_back.sv =====
// Back part: runs store read-modify-write and read-out, holds the output register.
module xpfec_back #(
    parameter int MAX_PARITY_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  xpfec_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(MAX_PARITY_BYTES)-1:0] i_addr,
    output logic                                o_cmd_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output xpfec_pkg::t_rkind                   o_kind,
    output logic [7:0]                          o_byte,
    output logic                                o_last,
    output logic [10:0]                         o_len,
    output logic [15:0]                         o_seq,
    output logic                                o_ovr
);
    import xpfec_pkg::*;

    localparam int AW = $clog2(MAX_PARITY_BYTES);

    // stage B: command waiting for its store data
    logic          r_b_valid;
    t_cmd          r_b_cmd;
    logic [AW-1:0] r_b_addr;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;

    logic          r_o_valid;
    t_rkind        r_o_kind;
    logic [7:0]    r_o_byte;
    logic          r_o_last;
    logic [10:0]   r_o_len;
    logic [15:0]   r_o_seq;
    logic          r_o_ovr;

    logic          out_free, b_fire, pop;
    logic          ram_we, ram_re;
    logic [7:0]    ram_wdata, ram_rdata, rd_eff;

    assign out_free = !r_o_valid || i_ready;
    assign b_fire   = r_b_valid && (!r_b_cmd.emit || out_free);
    assign pop      = i_cmd_valid && (!r_b_valid || b_fire);
    assign ram_re   = pop && (i_cmd.mem_op == MEM_XOR || i_cmd.mem_op == MEM_READ);
    assign ram_we   = b_fire && (r_b_cmd.mem_op == MEM_XOR || r_b_cmd.mem_op == MEM_WRITE);
    // forward a write that lands on the address read in the same cycle
    assign rd_eff    = r_byp_hit ? r_byp_data : ram_rdata;
    assign ram_wdata = (r_b_cmd.mem_op == MEM_XOR) ? (rd_eff ^ r_b_cmd.data) : r_b_cmd.data;

    xpfec_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARITY_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_cmd    <= i_cmd;
            r_b_addr   <= i_addr;
            r_byp_hit  <= ram_we && ram_re && (r_b_addr == i_addr);
            r_byp_data <= ram_wdata;
        end
        if (b_fire && r_b_cmd.emit) begin
            r_o_kind <= r_b_cmd.rkind;
            r_o_last <= r_b_cmd.last;
            r_o_len  <= r_b_cmd.len;
            r_o_seq  <= r_b_cmd.seq;
            r_o_ovr  <= r_b_cmd.ovr;
            if (r_b_cmd.mem_op == MEM_READ) begin
                r_o_byte <= rd_eff;
            end else if (r_b_cmd.rkind == RK_BYTE) begin
                r_o_byte <= r_b_cmd.data;
            end else begin
                r_o_byte <= 8'd0;
            end
        end
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire && r_b_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_pop = pop;
    assign o_valid   = r_o_valid;
    assign o_kind    = r_o_kind;
    assign o_byte    = r_o_byte;
    assign o_last    = r_o_last;
    assign o_len     = r_o_len;
    assign o_seq     = r_o_seq;
    assign o_ovr     = r_o_ovr;
endmodule

// ===== hw/rtl/xor_parity_packet_fec_encoder_core.sv =====
// Top level of the XOR parity packet FEC encoder.
//
// Slave stream: one beat per packet byte (tuser = 0) or per parity read
// request (tuser = 1). tlast marks the last byte of a packet. Packet header
// bytes are skipped except byte 3 (flags); payload bytes are XORed into a
// parity store, one read-modify-write per beat.
// Master stream: one result beat for every read request, for the packet byte
// that completes a group (ready notice, tuser = 0) and for a packet byte that
// drops pending parity (overrun). tlast marks the last parity packet byte.
// Throughput: one beat per cycle on both sides while the master side is not
// stalled; the store port pair (one read, one write per cycle) sets this. From
// slave accept a beat passes the command queue, then store read stage B into the output reg.
// A 4-entry command queue and the output register decouple the sides, so
// the slave side keeps taking beats while a result waits on tready; when the
// queue fills, s_tready drops until the receiver takes results again.
// Reset (synchronous, active low) empties queue and output, clears group
// state and sets packets per group to 4. The store itself is never cleared:
// only entries written in the current group are read back.
// Configuration: i_cfg_we writes packets per group; values outside 2..MAX_GROUP store 4.
module xor_parity_packet_fec_encoder_core #(
    parameter int MAX_GROUP        = 16,
    parameter int HEADER_BYTES     = 8,
    parameter int MAX_PARITY_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,    // packets per group
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,      // data_byte[7:0], packet_sequence[23:8],
                                        // next_sequence[39:24]
    input  logic        i_s_tuser,      // kind
    input  logic        i_s_tlast,      // last_of_packet
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,      // out_byte[7:0], parity_length[18:8],
                                        // parity_sequence[34:19], overrun[35], zero
    output logic [1:0]  o_m_tuser,      // result_kind
    output logic        o_m_tlast       // out_last
);
    import xpfec_pkg::*;

    localparam int AW = $clog2(MAX_PARITY_BYTES);
    localparam int QW = AW + $bits(t_cmd);

    logic          s_accept, q_full, q_valid, q_pop;
    t_cmd          f_cmd, q_cmd;
    logic [AW-1:0] f_addr, q_addr;
    logic [QW-1:0] q_dout;
    t_rkind        b_kind;
    logic [7:0]    b_byte;
    logic [10:0]   b_len;
    logic [15:0]   b_seq;
    logic          b_ovr;

    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && !q_full;

    xpfec_front #(
        .MAX_GROUP        (MAX_GROUP),
        .HEADER_BYTES     (HEADER_BYTES),
        .MAX_PARITY_BYTES (MAX_PARITY_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (s_accept),
        .i_kind      (i_s_tuser),
        .i_data      (i_s_tdata[7:0]),
        .i_last      (i_s_tlast),
        .i_pseq      (i_s_tdata[23:8]),
        .i_nseq      (i_s_tdata[39:24]),
        .o_cmd       (f_cmd),
        .o_addr      (f_addr)
    );

    // every accepted beat enqueues one command, even one that does nothing
    xpfec_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_data  ({f_addr, f_cmd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    assign q_cmd  = q_dout[$bits(t_cmd)-1:0];
    assign q_addr = q_dout[QW-1:$bits(t_cmd)];

    xpfec_back #(
        .MAX_PARITY_BYTES (MAX_PARITY_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .i_addr      (q_addr),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (b_kind),
        .o_byte      (b_byte),
        .o_last      (o_m_tlast),
        .o_len       (b_len),
        .o_seq       (b_seq),
        .o_ovr       (b_ovr)
    );

    assign o_m_tuser = b_kind;
    assign o_m_tdata = {4'b0000, b_ovr, b_seq, b_len, b_byte};
endmodule
